### rtl/three_axis_pd_velocity_regulator_macros.svh
// ----------------------------------------------------------------------------
// three axis pd velocity regulator assertion macros
// shared concurrent assertion forms, reset gated, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_PD_VELOCITY_REGULATOR_MACROS_SVH
`define THREE_AXIS_PD_VELOCITY_REGULATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TPDVR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpdvr same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TPDVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpdvr next-cycle check failed");

`endif

### rtl/tpdvr_pkg.sv
// ----------------------------------------------------------------------------
// tpdvr package
// shared types, codes and fixed point constants of the velocity regulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpdvr_pkg;

  // input request codes
  typedef enum logic [2:0] {
    CMD_GOAL  = 3'd0,
    CMD_POSE  = 3'd1,
    CMD_MVEL  = 3'd2,
    CMD_FIELD = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HORIZ_POS_GAIN    = 3'd0,
    REG_HORIZ_DAMP_GAIN   = 3'd1,
    REG_VERT_POS_GAIN     = 3'd2,
    REG_VERT_DAMP_GAIN    = 3'd3,
    REG_HORIZ_SPEED_LIMIT = 3'd4,
    REG_VERT_SPEED_LIMIT  = 3'd5,
    REG_YAW_POS_GAIN      = 3'd6,
    REG_YAW_DAMP_GAIN     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] horiz_pos_gain;
    logic [15:0] horiz_damp_gain;
    logic [15:0] vert_pos_gain;
    logic [15:0] vert_damp_gain;
    logic [30:0] horiz_speed_limit;
    logic [30:0] vert_speed_limit;
    logic [15:0] yaw_pos_gain;
    logic [15:0] yaw_damp_gain;
  } cfg_t;

  // per-stage load strobes of the six stage pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_ld_t;

  localparam int unsigned PipeDepth = 6;

  localparam logic [15:0] POSE_LOST_TICKS = 16'd10;
  localparam logic [15:0] AGE_MAX         = 16'hFFFF;

  // Q16.16 constants
  localparam logic [17:0] PI_Q        = 18'd205887;
  localparam logic [18:0] TWO_PI_Q    = 19'd411775;
  localparam logic [13:0] YAW_ERR_LIM = 14'd13107;

  // pi plus 10431 * 2pi, keeps the heading wrap operand non-negative
  localparam logic [34:0] WRAP_BIAS = 35'd4295430912;
  // floor(2^34 / 2pi) for the reciprocal quotient estimate
  localparam logic [15:0] RECIP_Q   = 16'd41721;

  // reset values
  localparam logic [15:0] GAIN_ONE_Q8 = 16'd256;
  localparam logic [30:0] LIMIT_RST   = 31'd65536;
  localparam logic [31:0] GOAL_Z_RST  = 32'd65536;

endpackage

### rtl/three_axis_pd_velocity_regulator.sv
// a tick request that emits gives its result through the six stage pipeline
// throughput: one request per cycle while input is not blocked, set by the
// six stage datapath pipeline; a stalled output only blocks input when all are full
// reset: asynchronous, active low; restores gains, limits, stored values
// and pose age at once, no clearing pass
// ----------------------------------------------------------------------------
// three axis pd velocity regulator
// stores goal, pose, velocities; each tick with a fresh pose emits a saturated velocity command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_axis_pd_velocity_regulator import tpdvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] val_x_i,
  input  logic signed [31:0] val_y_i,
  input  logic signed [31:0] val_z_i,
  input  logic signed [31:0] val_w_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] cmd_vel_x_o,
  output logic signed [31:0] cmd_vel_y_o,
  output logic signed [31:0] cmd_vel_z_o,
  output logic signed [31:0] cmd_yaw_rate_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

`include "three_axis_pd_velocity_regulator_macros.svh"

  cfg_t cfg;

  // stored goal, pose and velocity values
  logic signed [31:0] goal_pos_q [3];
  logic signed [31:0] pose_pos_q [3];
  logic signed [31:0] mvel_q     [3];
  logic signed [31:0] fvel_q     [3];
  logic signed [31:0] goal_hdg_q;
  logic signed [31:0] pose_hdg_q;
  logic signed [31:0] yaw_rate_q;
  logic [15:0]        age_q, age_d;

  logic                 in_accept;
  logic                 is_tick;
  logic                 emit;
  logic                 start;
  logic [PipeDepth-1:0] vld_q, vld_d;
  logic [PipeDepth-1:0] rdy;
  pipe_ld_t             ld;

  tpdvr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------------------
  // pose age and emit decision
  // ---------------------------------------------------------------------------

  assign in_accept = in_valid_i && in_ready_o;
  assign is_tick   = (cmd_i == CMD_TICK);

  // age counts up to its ceiling and sticks there
  assign age_d = (age_q == AGE_MAX) ? age_q : age_q + 16'd1;
  assign emit  = (age_d < POSE_LOST_TICKS);

  // only an emitting tick enters the pipeline; it snapshots the stored values
  assign start = in_valid_i && is_tick && emit;

  // ---------------------------------------------------------------------------
  // stored state, updated as each request is accepted
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        goal_pos_q[i] <= 32'sd0;
        pose_pos_q[i] <= 32'sd0;
        mvel_q[i]     <= 32'sd0;
        fvel_q[i]     <= 32'sd0;
      end
      goal_pos_q[2] <= GOAL_Z_RST;
      goal_hdg_q    <= 32'sd0;
      pose_hdg_q    <= 32'sd0;
      yaw_rate_q    <= 32'sd0;
      age_q         <= 16'd0;
    end else if (in_accept) begin
      case (cmd_i)
        CMD_GOAL: begin
          goal_pos_q[0] <= val_x_i;
          goal_pos_q[1] <= val_y_i;
          goal_pos_q[2] <= val_z_i;
          goal_hdg_q    <= val_w_i;
        end
        CMD_POSE: begin
          pose_pos_q[0] <= val_x_i;
          pose_pos_q[1] <= val_y_i;
          pose_pos_q[2] <= val_z_i;
          pose_hdg_q    <= val_w_i;
          age_q         <= 16'd0;
        end
        CMD_MVEL: begin
          mvel_q[0]  <= val_x_i;
          mvel_q[1]  <= val_y_i;
          mvel_q[2]  <= val_z_i;
          yaw_rate_q <= val_w_i;
        end
        CMD_FIELD: begin
          // w is not used by a field request
          fvel_q[0] <= val_x_i;
          fvel_q[1] <= val_y_i;
          fvel_q[2] <= val_z_i;
        end
        CMD_TICK: begin
          age_q <= age_d;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its content moves on,
  // so bubbles collapse and the last stage acts as the output register
  // ---------------------------------------------------------------------------

  always_comb begin
    rdy[PipeDepth-1] = !vld_q[PipeDepth-1] || out_ready_i;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) vld_d[0] = start;
    for (int k = 1; k < PipeDepth; k++) begin
      if (rdy[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ld.s1 = rdy[0] && start;
  assign ld.s2 = rdy[1] && vld_q[0];
  assign ld.s3 = rdy[2] && vld_q[1];
  assign ld.s4 = rdy[3] && vld_q[2];
  assign ld.s5 = rdy[4] && vld_q[3];
  assign ld.s6 = rdy[5] && vld_q[4];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[PipeDepth-1];

  // ---------------------------------------------------------------------------
  // datapaths: x and y share the horizontal gains, z uses the vertical set
  // ---------------------------------------------------------------------------

  tpdvr_axis u_axis_x (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .goal_i (goal_pos_q[0]),
    .pose_i (pose_pos_q[0]),
    .mvel_i (mvel_q[0]),
    .fvel_i (fvel_q[0]),
    .kp_i   (cfg.horiz_pos_gain),
    .kd_i   (cfg.horiz_damp_gain),
    .lim_i  (cfg.horiz_speed_limit),
    .cmd_o  (cmd_vel_x_o)
  );

  tpdvr_axis u_axis_y (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .goal_i (goal_pos_q[1]),
    .pose_i (pose_pos_q[1]),
    .mvel_i (mvel_q[1]),
    .fvel_i (fvel_q[1]),
    .kp_i   (cfg.horiz_pos_gain),
    .kd_i   (cfg.horiz_damp_gain),
    .lim_i  (cfg.horiz_speed_limit),
    .cmd_o  (cmd_vel_y_o)
  );

  tpdvr_axis u_axis_z (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .goal_i (goal_pos_q[2]),
    .pose_i (pose_pos_q[2]),
    .mvel_i (mvel_q[2]),
    .fvel_i (fvel_q[2]),
    .kp_i   (cfg.vert_pos_gain),
    .kd_i   (cfg.vert_damp_gain),
    .lim_i  (cfg.vert_speed_limit),
    .cmd_o  (cmd_vel_z_o)
  );

  tpdvr_yaw u_yaw (
    .clk_i      (clk_i),
    .ld_i       (ld),
    .goal_hdg_i (goal_hdg_q),
    .pose_hdg_i (pose_hdg_q),
    .yaw_rate_i (yaw_rate_q),
    .kp_i       (cfg.yaw_pos_gain),
    .kd_i       (cfg.yaw_damp_gain),
    .cmd_o      (cmd_yaw_rate_o)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an accepted emitting tick always occupies the first stage next cycle
  `TPDVR_ASSERT_NEXT(a_start_fills_s1, clk_i, rst_ni, start && in_ready_o, vld_q[0])
  // a pose request restarts the age count
  `TPDVR_ASSERT_NEXT(a_pose_clears_age, clk_i, rst_ni, in_accept && cmd_i == CMD_POSE, age_q == 16'd0)
  // a tick below the ceiling advances the age by exactly one
  `TPDVR_ASSERT_NEXT(a_tick_ages, clk_i, rst_ni, in_accept && is_tick && age_q != AGE_MAX, age_q == $past(age_q) + 16'd1)
  // input is only blocked when every stage holds a result and output stalls
  `TPDVR_ASSERT_IMPLIES(a_full_blocks, clk_i, rst_ni, !in_ready_o, (&vld_q) && !out_ready_i)

endmodule

### rtl/tpdvr_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpdvr configuration registers
// gains and speed limits, written through the configuration request channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpdvr_cfg_regs import tpdvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.horiz_pos_gain    <= GAIN_ONE_Q8;
      cfg_q.horiz_damp_gain   <= 16'd0;
      cfg_q.vert_pos_gain     <= GAIN_ONE_Q8;
      cfg_q.vert_damp_gain    <= 16'd0;
      cfg_q.horiz_speed_limit <= LIMIT_RST;
      cfg_q.vert_speed_limit  <= LIMIT_RST;
      cfg_q.yaw_pos_gain      <= GAIN_ONE_Q8;
      cfg_q.yaw_damp_gain     <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HORIZ_POS_GAIN:    cfg_q.horiz_pos_gain    <= cfg_data_i[15:0];
        REG_HORIZ_DAMP_GAIN:   cfg_q.horiz_damp_gain   <= cfg_data_i[15:0];
        REG_VERT_POS_GAIN:     cfg_q.vert_pos_gain     <= cfg_data_i[15:0];
        REG_VERT_DAMP_GAIN:    cfg_q.vert_damp_gain    <= cfg_data_i[15:0];
        REG_HORIZ_SPEED_LIMIT: cfg_q.horiz_speed_limit <= cfg_data_i[30:0];
        REG_VERT_SPEED_LIMIT:  cfg_q.vert_speed_limit  <= cfg_data_i[30:0];
        REG_YAW_POS_GAIN:      cfg_q.yaw_pos_gain      <= cfg_data_i[15:0];
        REG_YAW_DAMP_GAIN:     cfg_q.yaw_damp_gain     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/tpdvr_axis.sv
// ----------------------------------------------------------------------------
// tpdvr linear axis datapath
// pd term, speed clamp and saturating field add for one axis, six stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpdvr_axis import tpdvr_pkg::*; (
  input  logic               clk_i,
  input  pipe_ld_t           ld_i,
  input  logic signed [31:0] goal_i,
  input  logic signed [31:0] pose_i,
  input  logic signed [31:0] mvel_i,
  input  logic signed [31:0] fvel_i,
  input  logic [15:0]        kp_i,
  input  logic [15:0]        kd_i,
  input  logic [30:0]        lim_i,
  output logic signed [31:0] cmd_o
);

  logic signed [32:0] err_q;
  logic signed [31:0] mv1_q;
  logic signed [31:0] fv1_q, fv2_q, fv3_q;
  logic signed [49:0] pkp_d, pkp_q;
  logic signed [48:0] pkd_d, pkd_q;
  logic signed [50:0] acc;
  logic signed [42:0] shr;
  logic signed [42:0] lim_ext;
  logic signed [31:0] lim_pos;
  logic signed [31:0] vcl_d, vcl_q;
  logic signed [32:0] sum;
  logic signed [31:0] sat_d, res4_q, res5_q, res6_q;

  // stage 1: position error
  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      err_q <= $signed({goal_i[31], goal_i}) - $signed({pose_i[31], pose_i});
      mv1_q <= mvel_i;
      fv1_q <= fvel_i;
    end
  end

  // stage 2: gain products
  assign pkp_d = err_q * $signed({1'b0, kp_i});
  assign pkd_d = mv1_q * $signed({1'b0, kd_i});

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      pkp_q <= pkp_d;
      pkd_q <= pkd_d;
      fv2_q <= fv1_q;
    end
  end

  // stage 3: difference, floor shift back to Q16.16, speed clamp
  assign acc     = $signed({pkp_q[49], pkp_q}) - $signed({{2{pkd_q[48]}}, pkd_q});
  assign shr     = acc[50:8];
  assign lim_ext = $signed({12'd0, lim_i});
  assign lim_pos = $signed({1'b0, lim_i});

  always_comb begin
    if (shr > lim_ext) begin
      vcl_d = lim_pos;
    end else if (shr < -lim_ext) begin
      vcl_d = -lim_pos;
    end else begin
      vcl_d = shr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      vcl_q <= vcl_d;
      fv3_q <= fv2_q;
    end
  end

  // stage 4: field velocity add with 32 bit saturation
  assign sum = $signed({vcl_q[31], vcl_q}) + $signed({fv3_q[31], fv3_q});

  always_comb begin
    if (sum[32] != sum[31]) begin
      sat_d = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_d = sum[31:0];
    end
  end

  // stages 5 and 6 line up with the yaw path
  always_ff @(posedge clk_i) begin
    if (ld_i.s4) res4_q <= sat_d;
    if (ld_i.s5) res5_q <= res4_q;
    if (ld_i.s6) res6_q <= res5_q;
  end

  assign cmd_o = res6_q;

endmodule

### rtl/tpdvr_yaw.sv
// ----------------------------------------------------------------------------
// tpdvr yaw datapath
// heading error wrap by reciprocal quotient, error clamp and pd term
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpdvr_yaw import tpdvr_pkg::*; (
  input  logic               clk_i,
  input  pipe_ld_t           ld_i,
  input  logic signed [31:0] goal_hdg_i,
  input  logic signed [31:0] pose_hdg_i,
  input  logic signed [31:0] yaw_rate_i,
  input  logic [15:0]        kp_i,
  input  logic [15:0]        kd_i,
  output logic signed [31:0] cmd_o
);

  logic [34:0]        biased;
  logic [33:0]        u1_q, u2_q;
  logic [37:0]        qp_d, qp_q;
  logic [15:0]        quo;
  logic [34:0]        qc;
  logic [21:0]        r3_q, r1, r2;
  logic signed [20:0] dwrap;
  logic signed [14:0] d_d, d_q;
  logic               z4_q, z5_q;
  logic signed [31:0] mw1_q, mw2_q, mw3_q, mw4_q;
  logic signed [31:0] pkp_d, pkp_q;
  logic signed [48:0] pkd_d, pkd_q;
  logic signed [49:0] acc;
  logic signed [41:0] shr;
  logic signed [31:0] res_d, res_q;

  // stage 1: biased heading difference, always in [0, 2^34)
  assign biased = {{3{goal_hdg_i[31]}}, goal_hdg_i} - {{3{pose_hdg_i[31]}}, pose_hdg_i}
                + WRAP_BIAS;

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      u1_q  <= biased[33:0];
      mw1_q <= yaw_rate_i;
    end
  end

  // stage 2: quotient estimate, at most two short of the true quotient
  assign qp_d = 38'(u1_q[33:12]) * 38'(RECIP_Q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      qp_q  <= qp_d;
      u2_q  <= u1_q;
      mw2_q <= mw1_q;
    end
  end

  // stage 3: partial remainder, below three times 2pi
  assign quo = qp_q[37:22];
  assign qc  = 35'(quo) * 35'(TWO_PI_Q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      r3_q  <= u2_q[21:0] - qc[21:0];
      mw3_q <= mw2_q;
    end
  end

  // stage 4: two correction steps, re-center, clamp the error
  assign r1    = (r3_q >= 22'(TWO_PI_Q)) ? r3_q - 22'(TWO_PI_Q) : r3_q;
  assign r2    = (r1 >= 22'(TWO_PI_Q)) ? r1 - 22'(TWO_PI_Q) : r1;
  assign dwrap = $signed({2'b00, r2[18:0]}) - $signed({3'b000, PI_Q});

  always_comb begin
    if (dwrap > $signed({7'd0, YAW_ERR_LIM})) begin
      d_d = $signed({1'b0, YAW_ERR_LIM});
    end else if (dwrap < -$signed({7'd0, YAW_ERR_LIM})) begin
      d_d = -$signed({1'b0, YAW_ERR_LIM});
    end else begin
      d_d = dwrap[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      d_q   <= d_d;
      z4_q  <= (dwrap == 21'sd0);
      mw4_q <= mw3_q;
    end
  end

  // stage 5: gain products
  assign pkp_d = d_q * $signed({1'b0, kp_i});
  assign pkd_d = mw4_q * $signed({1'b0, kd_i});

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      pkp_q <= pkp_d;
      pkd_q <= pkd_d;
      z5_q  <= z4_q;
    end
  end

  // stage 6: difference, floor shift, saturate; exact zero error gives zero
  assign acc = $signed({{18{pkp_q[31]}}, pkp_q}) - $signed({pkd_q[48], pkd_q});
  assign shr = acc[49:8];

  always_comb begin
    if (z5_q) begin
      res_d = 32'sd0;
    end else if (shr[41:31] != {11{shr[41]}}) begin
      res_d = shr[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res_d = shr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s6) res_q <= res_d;
  end

  assign cmd_o = res_q;

endmodule

### tb/tpdvr_tb_pkg.sv
// ----------------------------------------------------------------------------
// velocity command scoreboard
// tracks stored goal, pose and velocities, predicts the command of each tick that emits and
// compares the commands coming out of the regulator in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpdvr_tb_pkg;
  import tpdvr_pkg::*;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] yaw;
  } vel_cmd_t;

  localparam longint HalfTurnQ16  = 205887;
  localparam longint FullTurnQ16  = 411775;
  localparam longint YawErrCapQ16 = 13107;
  localparam longint S32Max       = 64'sd2147483647;
  localparam longint S32Min       = -64'sd2147483648;

  class vel_cmd_scoreboard;
    cfg_t        cfg;
    longint      goal_pos[3];
    longint      goal_hdg;
    longint      pose_pos[3];
    longint      pose_hdg;
    longint      meas_vel[3];
    longint      meas_yaw_rate;
    longint      fld_vel[3];
    logic [15:0] pose_age;
    vel_cmd_t    pending_cmds[$];
    int          errors;

    function new();
      cfg.horiz_pos_gain    = GAIN_ONE_Q8;
      cfg.horiz_damp_gain   = '0;
      cfg.vert_pos_gain     = GAIN_ONE_Q8;
      cfg.vert_damp_gain    = '0;
      cfg.horiz_speed_limit = LIMIT_RST;
      cfg.vert_speed_limit  = LIMIT_RST;
      cfg.yaw_pos_gain      = GAIN_ONE_Q8;
      cfg.yaw_damp_gain     = '0;
      foreach (goal_pos[i]) begin
        goal_pos[i] = 0;
        pose_pos[i] = 0;
        meas_vel[i] = 0;
        fld_vel[i]  = 0;
      end
      goal_pos[2]   = 65536;
      goal_hdg      = 0;
      pose_hdg      = 0;
      meas_yaw_rate = 0;
      pose_age      = '0;
      errors        = 0;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (reg_idx_e'(idx))
        REG_HORIZ_POS_GAIN:    cfg.horiz_pos_gain    = data[15:0];
        REG_HORIZ_DAMP_GAIN:   cfg.horiz_damp_gain   = data[15:0];
        REG_VERT_POS_GAIN:     cfg.vert_pos_gain     = data[15:0];
        REG_VERT_DAMP_GAIN:    cfg.vert_damp_gain    = data[15:0];
        REG_HORIZ_SPEED_LIMIT: cfg.horiz_speed_limit = data[30:0];
        REG_VERT_SPEED_LIMIT:  cfg.vert_speed_limit  = data[30:0];
        REG_YAW_POS_GAIN:      cfg.yaw_pos_gain      = data[15:0];
        REG_YAW_DAMP_GAIN:     cfg.yaw_damp_gain     = data[15:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // q24.24 products back to q16.16 by an arithmetic shift, i.e. floor
    function longint axis_vel(int i, logic [15:0] kp, logic [15:0] kd, logic [30:0] lim);
      longint lim_q;
      longint v;
      lim_q = longint'(lim);
      v = ((goal_pos[i] - pose_pos[i]) * longint'(kp) - meas_vel[i] * longint'(kd)) >>> 8;
      v = sat(v, -lim_q, lim_q);
      return sat(v + fld_vel[i], S32Min, S32Max);
    endfunction

    function longint yaw_rate();
      longint m;
      longint d;
      m = (goal_hdg - pose_hdg + HalfTurnQ16) % FullTurnQ16;
      if (m < 0) m += FullTurnQ16;
      d = m - HalfTurnQ16;
      // an exact zero error skips the damping term too
      if (d == 0) return 0;
      d = sat(d, -YawErrCapQ16, YawErrCapQ16);
      return sat((d * longint'(cfg.yaw_pos_gain) -
                  meas_yaw_rate * longint'(cfg.yaw_damp_gain)) >>> 8, S32Min, S32Max);
    endfunction

    function void note_request(logic [2:0] cmd, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z,
                               logic signed [31:0] w);
      vel_cmd_t c;
      longint   v;
      case (cmd)
        CMD_GOAL: begin
          goal_pos[0] = x; goal_pos[1] = y; goal_pos[2] = z;
          goal_hdg = w;
        end
        CMD_POSE: begin
          pose_pos[0] = x; pose_pos[1] = y; pose_pos[2] = z;
          pose_hdg = w;
          pose_age = '0;
        end
        CMD_MVEL: begin
          meas_vel[0] = x; meas_vel[1] = y; meas_vel[2] = z;
          meas_yaw_rate = w;
        end
        CMD_FIELD: begin
          fld_vel[0] = x; fld_vel[1] = y; fld_vel[2] = z;
        end
        CMD_TICK: begin
          if (pose_age != AGE_MAX) pose_age = pose_age + 16'd1;
          if (pose_age < POSE_LOST_TICKS) begin
            v = axis_vel(0, cfg.horiz_pos_gain, cfg.horiz_damp_gain, cfg.horiz_speed_limit);
            c.vx = v[31:0];
            v = axis_vel(1, cfg.horiz_pos_gain, cfg.horiz_damp_gain, cfg.horiz_speed_limit);
            c.vy = v[31:0];
            v = axis_vel(2, cfg.vert_pos_gain, cfg.vert_damp_gain, cfg.vert_speed_limit);
            c.vz = v[31:0];
            v = yaw_rate();
            c.yaw = v[31:0];
            pending_cmds = {pending_cmds, c};
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(vel_cmd_t got);
      vel_cmd_t want;
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none actual %0d %0d %0d %0d",
                 $time, got.vx, got.vy, got.vz, got.yaw);
        return;
      end
      want = pending_cmds.pop_front();
      compare_field("cmd_vel_x", want.vx, got.vx);
      compare_field("cmd_vel_y", want.vy, got.vy);
      compare_field("cmd_vel_z", want.vz, got.vz);
      compare_field("cmd_yaw_rate", want.yaw, got.yaw);
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// three axis pd velocity regulator testbench
// directed corner requests, then random pose and tick sequences over several
// gain and limit settings with random idling on both channels; every command
// is checked against a scoreboard that tracks the regulator's stored values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tpdvr_pkg::*;
  import tpdvr_tb_pkg::*;

  localparam int NumRegs       = 8;
  localparam int SettleCycles  = 12;   // pipeline is six deep
  localparam int HoldCycles    = 200;
  localparam int ItemsPerPhase = 175;
  localparam int AgeBurstTicks = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         cmd_i;
  logic signed [31:0] val_x_i;
  logic signed [31:0] val_y_i;
  logic signed [31:0] val_z_i;
  logic signed [31:0] val_w_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] cmd_vel_x_o;
  logic signed [31:0] cmd_vel_y_o;
  logic signed [31:0] cmd_vel_z_o;
  logic signed [31:0] cmd_yaw_rate_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  vel_cmd_scoreboard sb = new();

  // idle percentages of the two sides, changed per phase
  int          tx_idle_pct = 36;
  int          rx_idle_pct = 72;
  // the stimulus asks, the receiver process counts the hold-off itself
  bit          hold_requested = 1'b0;
  logic [31:0] cfg_plan [NumRegs];

  three_axis_pd_velocity_regulator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .val_x_i        (val_x_i),
    .val_y_i        (val_y_i),
    .val_z_i        (val_z_i),
    .val_w_i        (val_w_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_vel_x_o    (cmd_vel_x_o),
    .cmd_vel_y_o    (cmd_vel_y_o),
    .cmd_vel_z_o    (cmd_vel_z_o),
    .cmd_yaw_rate_o (cmd_yaw_rate_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, far above the slowest correct run
  initial begin
    #(30_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // value generators
  // --------------------------------------------------------------------------

  // mostly a few meters around zero so the clamps are not always hit,
  // sometimes full range or the extremes
  function automatic logic signed [31:0] rand_q16();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h000F_FFFF);
        v = v - 32'sh0008_0000;
      end
    endcase
    return v;
  endfunction

  // headings mostly within about +-4 rad, sometimes anywhere
  function automatic logic signed [31:0] rand_heading();
    logic signed [31:0] v;
    if ($urandom_range(0, 4) == 0) begin
      v = $urandom;
    end else begin
      v = $urandom_range(0, 524288);
      v = v - 32'sh0004_0000;
    end
    return v;
  endfunction

  // random register image; upper data bits are random and must be dropped
  task automatic plan_random_cfg();
    for (int i = 0; i < NumRegs; i++) begin
      if (reg_idx_e'(i) == REG_HORIZ_SPEED_LIMIT || reg_idx_e'(i) == REG_VERT_SPEED_LIMIT) begin
        case ($urandom_range(0, 5))
          0: cfg_plan[i] = $urandom;
          1: cfg_plan[i] = {1'($urandom_range(0, 1)), 31'd0};
          default: cfg_plan[i] = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h4_0000))};
        endcase
      end else begin
        cfg_plan[i] = $urandom & 32'hFFFF_0000;
        if ($urandom_range(0, 3) == 0) cfg_plan[i][15:0] = 16'($urandom);
        else cfg_plan[i][15:0] = 16'($urandom_range(0, 1024));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one request and return at the edge that takes it; valid stays up so
  // a back to back request needs no second assignment in the same step
  task automatic send_req(input logic [2:0] cmd, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z,
                          input logic signed [31:0] w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    val_x_i    <= x;
    val_y_i    <= y;
    val_z_i    <= z;
    val_w_i    <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, x, y, z, w);
  endtask

  // tick payload is don't care, keep it toggling
  task automatic send_tick();
    send_req(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  // stop offering, wait for every command, then let the pipeline settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_cfg();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= cfg_plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(3'(i), cfg_plan[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly pose followed by a run of ticks, which is what gives commands;
  // the rest is lone updates, stray ticks past the timeout and unused codes
  task automatic random_burst(input int n);
    int                 done;
    int                 pick;
    int                 len;
    logic signed [31:0] hdg;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // now and then the same heading as the goal, zero yaw error
        hdg = ($urandom_range(0, 9) == 0) ? sb.goal_hdg[31:0] : rand_heading();
        send_req(CMD_POSE, rand_q16(), rand_q16(), rand_q16(), hdg);
        len = $urandom_range(1, 11);
        repeat (len) send_tick();
        done += len + 1;
      end else if (pick < 65) begin
        send_req(CMD_GOAL, rand_q16(), rand_q16(), rand_q16(), rand_heading());
        done++;
      end else if (pick < 75) begin
        send_req(CMD_MVEL, rand_q16(), rand_q16(), rand_q16(), rand_q16());
        done++;
      end else if (pick < 83) begin
        send_req(CMD_FIELD, rand_q16(), rand_q16(), rand_q16(), $urandom);
        done++;
      end else if (pick < 90) begin
        send_tick();
        done++;
      end else if (pick < 95) begin
        // unused codes change nothing, not counted
        send_req(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        // ticks with no fresh pose, can run the age past the timeout
        len = $urandom_range(3, 14);
        repeat (len) send_tick();
        done += len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: check every accepted command, then pick next ready
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result('{cmd_vel_x_o, cmd_vel_y_o, cmd_vel_z_o, cmd_yaw_rate_o});
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_requested) begin
        // long hold-off so the pipeline fills and stalls the input
        hold_requested = 1'b0;
        hold_left      = HoldCycles;
        out_ready_i    <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_GOAL;
    val_x_i     = '0;
    val_y_i     = '0;
    val_z_i     = '0;
    val_w_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_HORIZ_POS_GAIN;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains: tick before any pose still commands, goal z starts at 1.0
    send_tick();
    // unused codes
    send_req(3'd5, $urandom, $urandom, $urandom, $urandom);
    send_req(3'd6, $urandom, $urandom, $urandom, $urandom);
    send_req(3'd7, $urandom, $urandom, $urandom, $urandom);
    // field item with a nonzero w, which must be ignored
    send_req(CMD_FIELD, 32'sh0000_4000, -32'sh0000_4000, 32'sh0, 32'sh1234_5678);
    send_tick();

    // all gains and limits at their top, data upper bits set
    quiesce();
    foreach (cfg_plan[i]) cfg_plan[i] = 32'hFFFF_FFFF;
    apply_cfg();
    send_req(CMD_GOAL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    // huge heading error, wrap has to reduce it many turns
    send_req(CMD_POSE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_req(CMD_MVEL, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF);
    send_req(CMD_FIELD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, $urandom);
    send_tick();
    send_req(CMD_FIELD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, $urandom);
    send_tick();
    send_req(CMD_MVEL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_tick();
    // goal heading three whole turns from the pose heading: zero yaw error
    send_req(CMD_GOAL, 32'sh0, 32'sh0, 32'sh0, 32'sh8000_0000 + 32'sd1235325);
    send_tick();
    // smallest nonzero error
    send_req(CMD_GOAL, 32'sh0, 32'sh0, 32'sh0, 32'sh8000_0001);
    send_tick();

    // pose timeout: nine ticks command, the tenth does not
    send_req(CMD_POSE, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 32'sh0000_1000);
    repeat (10) send_tick();

    // zero gains and limits: command is the field velocity alone
    quiesce();
    foreach (cfg_plan[i]) cfg_plan[i] = 32'h0;
    apply_cfg();
    send_req(CMD_POSE, rand_q16(), rand_q16(), rand_q16(), rand_heading());
    send_tick();

    // fresh pose, then ticks running well past the timeout, which give nothing there
    send_req(CMD_POSE, rand_q16(), rand_q16(), rand_q16(), rand_heading());
    repeat (AgeBurstTicks) send_tick();

    // random phases, a new setting each, idle pattern changes every two
    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      plan_random_cfg();
      apply_cfg();
      case (ph / 2)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 5) begin
        // receiver backs off while pose and tick requests keep coming
        hold_requested = 1'b1;
        repeat (4) begin
          send_req(CMD_POSE, rand_q16(), rand_q16(), rand_q16(), rand_heading());
          repeat (8) send_tick();
        end
      end
      random_burst(ItemsPerPhase);
    end

    quiesce();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
